// ----- hdl/ihc_pkg.sv -----
package ihc_pkg;

  localparam int WORD_W    = 32;
  localparam int HALF_W    = 16;
  localparam int LEN_W     = 16;
  localparam int IHL_W     = 4;
  localparam int PROTO_W   = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [3:0]         IP_VERSION4   = 4'd4;
  localparam logic [LEN_W-1:0]   MIN_HDR_BYTES = 16'd20;
  localparam logic [HALF_W-1:0]  CSUM_GOOD     = 16'hffff;
  localparam logic [WORD_W-1:0]  BCAST_ALL     = 32'hffff_ffff;
  localparam int                 MF_BIT_POS    = 13;

  localparam logic [PROTO_W-1:0] PROTO_ICMP = 8'd1;
  localparam logic [PROTO_W-1:0] PROTO_TCP  = 8'd6;
  localparam logic [PROTO_W-1:0] PROTO_UDP  = 8'd17;

  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_ADDR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NET_MASK   = 2'd1;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NOT_V4     = 3'd1,
    ST_BAD_HLEN   = 3'd2,
    ST_BAD_TLEN   = 3'd3,
    ST_FRAGMENT   = 3'd4,
    ST_BAD_CSUM   = 3'd5,
    ST_WRONG_DEST = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    PC_ICMP  = 2'd0,
    PC_UDP   = 2'd1,
    PC_TCP   = 2'd2,
    PC_OTHER = 2'd3
  } proto_class_t;

  typedef enum logic [1:0] {
    DK_OWN    = 2'd0,
    DK_BCAST  = 2'd1,
    DK_SUBNET = 2'd2,
    DK_NONE   = 2'd3
  } dest_kind_t;

  // verdict request from the front end; status ST_OK means all checks up to
  // and including the checksum passed
  typedef struct packed {
    status_t              status;
    logic [PROTO_W-1:0]   protocol;
    logic [LEN_W-1:0]     total_len;
    logic [IHL_W-1:0]     hdr_words;
    logic [WORD_W-1:0]    src_addr;
    logic [WORD_W-1:0]    dst_addr;
  } req_t;

  typedef struct packed {
    status_t              status;
    proto_class_t         proto_class;
    logic [PROTO_W-1:0]   protocol;
    logic [LEN_W-1:0]     payload_len;
    dest_kind_t           dest_kind;
    logic [WORD_W-1:0]    source_addr;
    logic [WORD_W-1:0]    dest_addr;
  } res_t;

  // ones-complement add of both halves of a word into the running sum
  function automatic logic [HALF_W-1:0] csum_add_word(input logic [HALF_W-1:0] acc,
                                                      input logic [WORD_W-1:0] w);
    logic [HALF_W+1:0] s;
    logic [HALF_W:0]   t;
    s = (HALF_W+2)'(acc) + (HALF_W+2)'(w[WORD_W-1:HALF_W]) + (HALF_W+2)'(w[HALF_W-1:0]);
    t = (HALF_W+1)'(s[HALF_W-1:0]) + (HALF_W+1)'(s[HALF_W+1:HALF_W]);
    return t[HALF_W-1:0] + HALF_W'(t[HALF_W]);
  endfunction

endpackage

// ----- hdl/ihc_fifo.sv -----
module ihc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ----- hdl/ihc_front.sv -----
module ihc_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 word_valid,
  input  logic [31:0]          header_word,
  input  logic                 first_word,
  input  logic [15:0]          frame_len,
  output logic                 req_valid,
  output ihc_pkg::req_t        req
);

  logic                         open_r, open_nxt;
  logic [ihc_pkg::IHL_W-1:0]    word_idx_r, word_idx_nxt;
  logic [ihc_pkg::IHL_W-1:0]    hdr_words_r, hdr_words_nxt;
  logic [ihc_pkg::LEN_W-1:0]    total_len_r, total_len_nxt;
  logic [ihc_pkg::HALF_W-1:0]   sum_r, sum_nxt;
  logic [ihc_pkg::PROTO_W-1:0]  proto_r, proto_nxt;
  logic [ihc_pkg::WORD_W-1:0]   src_r, src_nxt;
  logic [ihc_pkg::WORD_W-1:0]   dst_r, dst_nxt;

  logic [3:0]                   ver;
  logic [ihc_pkg::IHL_W-1:0]    ihl;
  logic [ihc_pkg::LEN_W-1:0]    hlen;
  logic [ihc_pkg::LEN_W-1:0]    tlen;
  logic [ihc_pkg::HALF_W-1:0]   sum_word;
  logic                         last_word;

  assign ver       = header_word[31:28];
  assign ihl       = header_word[27:24];
  assign hlen      = {10'd0, ihl, 2'b00};
  assign tlen      = header_word[15:0];
  assign sum_word  = ihc_pkg::csum_add_word(first_word ? '0 : sum_r, header_word);
  assign last_word = ({1'b0, word_idx_r} + 5'd1) >= {1'b0, hdr_words_r};

  always_comb begin
    open_nxt      = open_r;
    word_idx_nxt  = word_idx_r;
    hdr_words_nxt = hdr_words_r;
    total_len_nxt = total_len_r;
    sum_nxt       = sum_r;
    proto_nxt     = proto_r;
    src_nxt       = src_r;
    dst_nxt       = dst_r;
    req_valid     = 1'b0;
    req           = '0;
    req.status    = ihc_pkg::ST_OK;

    if (word_valid && first_word) begin
      // a first word always restarts, abandoning any open packet
      hdr_words_nxt = ihl;
      total_len_nxt = tlen;
      sum_nxt       = sum_word;
      word_idx_nxt  = 4'd1;
      open_nxt      = 1'b0;
      if (ver != ihc_pkg::IP_VERSION4) begin
        req_valid  = 1'b1;
        req.status = ihc_pkg::ST_NOT_V4;
      end else if (hlen < ihc_pkg::MIN_HDR_BYTES || hlen > frame_len) begin
        req_valid  = 1'b1;
        req.status = ihc_pkg::ST_BAD_HLEN;
      end else if (tlen > frame_len || tlen < hlen) begin
        req_valid  = 1'b1;
        req.status = ihc_pkg::ST_BAD_TLEN;
      end else begin
        open_nxt = 1'b1;
      end
    end else if (word_valid && open_r) begin
      sum_nxt      = sum_word;
      word_idx_nxt = word_idx_r + 4'd1;
      case (word_idx_r)
        4'd2:    proto_nxt = header_word[23:16];
        4'd3:    src_nxt   = header_word;
        4'd4:    dst_nxt   = header_word;
        default: ;
      endcase
      if (word_idx_r == 4'd1 && header_word[ihc_pkg::MF_BIT_POS]) begin
        req_valid  = 1'b1;
        req.status = ihc_pkg::ST_FRAGMENT;
        open_nxt   = 1'b0;
      end else if (last_word) begin
        req_valid     = 1'b1;
        open_nxt      = 1'b0;
        req.status    = (sum_word == ihc_pkg::CSUM_GOOD) ? ihc_pkg::ST_OK
                                                         : ihc_pkg::ST_BAD_CSUM;
        req.protocol  = proto_nxt;
        req.total_len = total_len_r;
        req.hdr_words = hdr_words_r;
        req.src_addr  = src_nxt;
        req.dst_addr  = dst_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r     <= 1'b0;
      word_idx_r <= '0;
    end else begin
      open_r     <= open_nxt;
      word_idx_r <= word_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hdr_words_r <= hdr_words_nxt;
    total_len_r <= total_len_nxt;
    sum_r       <= sum_nxt;
    proto_r     <= proto_nxt;
    src_r       <= src_nxt;
    dst_r       <= dst_nxt;
  end

endmodule

// ----- hdl/ihc_back.sv -----
module ihc_back (
  input  logic                 req_empty,
  input  ihc_pkg::req_t        req,
  output logic                 req_pop,
  input  logic                 res_full,
  output logic                 res_push,
  output ihc_pkg::res_t        res,
  input  logic [31:0]          local_addr,
  input  logic [31:0]          net_mask
);

  logic [31:0]          subnet_bc;
  ihc_pkg::dest_kind_t  kind;
  ihc_pkg::proto_class_t cls;

  assign subnet_bc = local_addr | ~net_mask;
  assign req_pop   = !req_empty && !res_full;
  assign res_push  = req_pop;

  always_comb begin
    if (req.dst_addr == local_addr) begin
      kind = ihc_pkg::DK_OWN;
    end else if (req.dst_addr == ihc_pkg::BCAST_ALL) begin
      kind = ihc_pkg::DK_BCAST;
    end else if (req.dst_addr == subnet_bc) begin
      kind = ihc_pkg::DK_SUBNET;
    end else begin
      kind = ihc_pkg::DK_NONE;
    end
  end

  always_comb begin
    unique case (req.protocol)
      ihc_pkg::PROTO_ICMP: cls = ihc_pkg::PC_ICMP;
      ihc_pkg::PROTO_UDP:  cls = ihc_pkg::PC_UDP;
      ihc_pkg::PROTO_TCP:  cls = ihc_pkg::PC_TCP;
      default:             cls = ihc_pkg::PC_OTHER;
    endcase
  end

  always_comb begin
    res = '0;
    if (req.status != ihc_pkg::ST_OK) begin
      res.status = req.status;
    end else begin
      res.status      = (kind == ihc_pkg::DK_NONE) ? ihc_pkg::ST_WRONG_DEST : ihc_pkg::ST_OK;
      res.proto_class = cls;
      res.protocol    = req.protocol;
      res.payload_len = req.total_len - {10'd0, req.hdr_words, 2'b00};
      res.dest_kind   = kind;
      res.source_addr = req.src_addr;
      res.dest_addr   = req.dst_addr;
    end
  end

endmodule

// ----- hdl/ipv4_header_checker_core.sv -----
// IPv4 header checker. Header words enter one per cycle on the push/full side; the
// first word of each packet is flagged and carries the frame length. Every word is
// folded into a ones-complement checksum as it arrives, so a word is taken in every
// cycle as long as full is low. Each packet yields one verdict, produced by the front
// end on the word that settles it (first word, second word for a fragment, or the last
// header word), then shown on the result side. Verdicts pass in order through a
// request queue and a result queue, each QUEUE_DEPTH entries deep; full rises only
// while the request queue is full, which happens when results are not popped.
// Destination checks use local_addr and net_mask as written through the cfg port;
// write them only while no packet is in flight.
module ipv4_header_checker_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_push,
  output logic        in_full,
  input  logic [31:0] in_header_word,
  input  logic        in_first_word,
  input  logic [15:0] in_frame_len,

  output logic        out_empty,
  input  logic        out_pop,
  output logic [2:0]  out_status,
  output logic [1:0]  out_proto_class,
  output logic [7:0]  out_protocol,
  output logic [15:0] out_payload_len,
  output logic [1:0]  out_dest_kind,
  output logic [31:0] out_source_addr,
  output logic [31:0] out_dest_addr,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [31:0]   local_addr_r;
  logic [31:0]   net_mask_r;

  logic          word_valid;
  logic          req_wr;
  ihc_pkg::req_t req_in, req_out;
  logic          req_full, req_empty, req_pop;
  logic          res_full, res_push;
  ihc_pkg::res_t res_in, res_out;

  assign cfg_ready  = 1'b1;
  assign word_valid = in_push && !req_full;
  assign in_full    = req_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_addr_r <= '0;
      net_mask_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ihc_pkg::CFG_LOCAL_ADDR: local_addr_r <= cfg_data;
        ihc_pkg::CFG_NET_MASK:   net_mask_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  ihc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .word_valid  (word_valid),
    .header_word (in_header_word),
    .first_word  (in_first_word),
    .frame_len   (in_frame_len),
    .req_valid   (req_wr),
    .req         (req_in)
  );

  ihc_fifo #(
    .WIDTH ($bits(ihc_pkg::req_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_req_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (req_wr),
    .wr_data (req_in),
    .full    (req_full),
    .rd_en   (req_pop),
    .rd_data (req_out),
    .empty   (req_empty)
  );

  ihc_back u_back (
    .req_empty  (req_empty),
    .req        (req_out),
    .req_pop    (req_pop),
    .res_full   (res_full),
    .res_push   (res_push),
    .res        (res_in),
    .local_addr (local_addr_r),
    .net_mask   (net_mask_r)
  );

  ihc_fifo #(
    .WIDTH ($bits(ihc_pkg::res_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (res_in),
    .full    (res_full),
    .rd_en   (out_pop),
    .rd_data (res_out),
    .empty   (out_empty)
  );

  assign out_status      = res_out.status;
  assign out_proto_class = res_out.proto_class;
  assign out_protocol    = res_out.protocol;
  assign out_payload_len = res_out.payload_len;
  assign out_dest_kind   = res_out.dest_kind;
  assign out_source_addr = res_out.source_addr;
  assign out_dest_addr   = res_out.dest_addr;

endmodule

// ----- hdl/ihc_checker.sv -----
module ihc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_empty,
  input logic        out_pop,
  input logic [2:0]  out_status,
  input logic [1:0]  out_proto_class,
  input logic [7:0]  out_protocol,
  input logic [15:0] out_payload_len,
  input logic [1:0]  out_dest_kind,
  input logic [31:0] out_source_addr,
  input logic [31:0] out_dest_addr
);

  logic early_fail;

  assign early_fail = out_status == ihc_pkg::ST_NOT_V4 || out_status == ihc_pkg::ST_BAD_HLEN ||
                      out_status == ihc_pkg::ST_BAD_TLEN || out_status == ihc_pkg::ST_FRAGMENT ||
                      out_status == ihc_pkg::ST_BAD_CSUM;

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_status <= ihc_pkg::ST_WRONG_DEST)
    else $error("status code out of range");

  a_fail_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && early_fail) |-> (out_proto_class == 2'd0 && out_protocol == 8'd0 &&
      out_payload_len == 16'd0 && out_dest_kind == 2'd0 &&
      out_source_addr == 32'd0 && out_dest_addr == 32'd0))
    else $error("failed verdict carries nonzero fields");

  a_dest_match: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> ((out_status == ihc_pkg::ST_WRONG_DEST) == (out_dest_kind == ihc_pkg::DK_NONE)))
    else $error("wrong destination status and dest kind disagree");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_status) && $stable(out_dest_addr)))
    else $error("pending result changed before pop");

endmodule

bind ipv4_header_checker_core ihc_checker u_ihc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_empty       (out_empty),
  .out_pop         (out_pop),
  .out_status      (out_status),
  .out_proto_class (out_proto_class),
  .out_protocol    (out_protocol),
  .out_payload_len (out_payload_len),
  .out_dest_kind   (out_dest_kind),
  .out_source_addr (out_source_addr),
  .out_dest_addr   (out_dest_addr)
);
